[design/prhp_pkg.sv]
// Shared types, constants and helpers for the profiling record header parser.
package prhp_pkg;

    // Record geometry
    localparam int RECORD_BYTES = 64;
    localparam int POS_W        = $clog2(RECORD_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(RECORD_BYTES - 1);

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int EXT_W   = 32;
    localparam int SKIP_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Header codes
    localparam logic [BYTE_W-1:0] HDR_PAD       = 8'h00;
    localparam logic [BYTE_W-1:0] HDR_END       = 8'h01;
    localparam logic [BYTE_W-1:0] HDR_EXT_LO    = 8'h20;
    localparam logic [BYTE_W-1:0] HDR_PAYLOAD   = 8'h40;
    localparam logic [BYTE_W-1:0] HDR_SIZE_MASK = 8'h30;
    localparam logic [BYTE_W-1:0] HDR_TIMESTAMP = 8'h71;
    localparam logic [BYTE_W-1:0] HDR_UNINIT    = 8'hFF;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_EXT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    // Byte held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_item_t;

    // One record summary
    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] packet_count;
        logic               end_seen;
        logic [EXT_W-1:0]   extended_total;
    } summary_t;

    // Payload length coded in header bits [5:4]: 1, 2, 4 or 8 bytes
    function automatic logic [SKIP_W-1:0] payload_len(input logic [BYTE_W-1:0] hdr);
        logic [SKIP_W-1:0] len;
        len = SKIP_W'(1) << hdr[5:4];
        return len;
    endfunction

endpackage

[design/prhp_if.sv]
// Channel interfaces: record byte stream in, record summary out.
interface prhp_byte_if;
    import prhp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface prhp_result_if;
    import prhp_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [COUNT_W-1:0] packet_count;
    logic               end_seen;
    logic [EXT_W-1:0]   extended_total;

    modport source (output valid, output status, output packet_count, output end_seen,
                    output extended_total, input ready);
    modport sink   (input valid, input status, input packet_count, input end_seen,
                    input extended_total, output ready);
endinterface

[design/prhp_in_stage.sv]
// Input register: captures one record byte per transaction.
module prhp_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    prhp_byte_if.sink             record,
    input  logic                  take,
    output prhp_pkg::byte_item_t  item
);
    import prhp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              accept;

    // Free when empty or when the held byte leaves this cycle
    assign record.ready = !valid_reg || take;
    assign accept       = record.valid && record.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= record.data_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

[design/prhp_walker.sv]
// Header walker: per-record parse state, updated once per consumed byte.
module prhp_walker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  prhp_pkg::byte_item_t  item,
    input  logic                  out_free,
    output logic                  take,
    output logic                  sum_valid,
    output prhp_pkg::summary_t    summary
);
    import prhp_pkg::*;

    phase_t             phase_reg, phase_next, phase_upd;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next, skip_upd;
    logic [COUNT_W-1:0] packets_reg, packets_next, packets_upd;
    logic               closed_reg, closed_next, closed_upd;
    logic [EXT_W-1:0]   ext_reg, ext_next, ext_upd;
    logic               cnt_inc;
    logic               ext_inc;
    logic               last;
    logic [BYTE_W-1:0]  b;
    logic [SKIP_W-1:0]  skip_dec;

    assign b    = item.data;
    assign last = (pos_reg == POS_LAST);

    // A last byte waits only if the summary cannot be stored
    assign take      = item.valid && (!last || out_free);
    assign sum_valid = take && last;

    assign skip_dec = (skip_reg != '0) ? skip_reg - SKIP_W'(1) : skip_reg;

    // Next phase
    always_comb
    begin
        phase_upd = phase_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (b < HDR_EXT_LO)
                begin
                    if (b == HDR_END)
                    begin
                        phase_upd = PH_DONE;
                    end
                end
                else if (b < HDR_PAYLOAD)
                begin
                    if (!last)
                    begin
                        phase_upd = PH_EXT;
                    end
                end
                else if ((b | HDR_SIZE_MASK) == HDR_UNINIT ||
                         (b | HDR_SIZE_MASK) == HDR_TIMESTAMP)
                begin
                    phase_upd = PH_DONE;
                end
                else
                begin
                    phase_upd = PH_SKIP;
                end
            end
            PH_EXT:
            begin
                phase_upd = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (skip_dec == '0)
                begin
                    phase_upd = PH_HEADER;
                end
            end
            PH_DONE:
            begin
                phase_upd = PH_DONE;
            end
            default:
            begin
                phase_upd = PH_HEADER;
            end
        endcase
    end

    // Per-phase data updates
    always_comb
    begin
        cnt_inc    = 1'b0;
        ext_inc    = 1'b0;
        closed_upd = closed_reg;
        skip_upd   = skip_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (b < HDR_EXT_LO)
                begin
                    cnt_inc = (b != HDR_PAD);
                    if (b == HDR_END)
                    begin
                        closed_upd = 1'b1;
                    end
                end
                else if (b < HDR_PAYLOAD)
                begin
                    ext_inc = 1'b1;
                    // real header falls outside the record: count it anyway
                    cnt_inc = last;
                end
                else if ((b | HDR_SIZE_MASK) == HDR_UNINIT)
                begin
                    closed_upd = 1'b0;
                end
                else
                begin
                    cnt_inc = 1'b1;
                    if ((b | HDR_SIZE_MASK) == HDR_TIMESTAMP)
                    begin
                        closed_upd = 1'b1;
                    end
                    else
                    begin
                        skip_upd = payload_len(b);
                    end
                end
            end
            PH_EXT:
            begin
                cnt_inc  = (b != HDR_PAD);
                skip_upd = payload_len(b);
            end
            PH_SKIP:
            begin
                skip_upd = skip_dec;
            end
            PH_DONE:
            begin
                skip_upd = skip_reg;
            end
            default:
            begin
                skip_upd = skip_reg;
            end
        endcase
    end

    // Saturating packet count, wrapping extended count
    assign packets_upd = (cnt_inc && packets_reg != COUNT_MAX) ?
                         packets_reg + COUNT_W'(1) : packets_reg;
    assign ext_upd     = ext_inc ? ext_reg + EXT_W'(1) : ext_reg;

    // Record summary from the updated state
    assign summary.status         = (phase_upd == PH_DONE) && !closed_upd;
    assign summary.packet_count   = packets_upd;
    assign summary.end_seen       = closed_upd;
    assign summary.extended_total = ext_upd;

    // Commit, clearing per-record state after the last byte
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        skip_next    = skip_reg;
        packets_next = packets_reg;
        closed_next  = closed_reg;
        ext_next     = ext_reg;
        if (take)
        begin
            ext_next = ext_upd;
            if (last)
            begin
                phase_next   = PH_HEADER;
                pos_next     = '0;
                skip_next    = '0;
                packets_next = '0;
                closed_next  = 1'b0;
            end
            else
            begin
                phase_next   = phase_upd;
                pos_next     = pos_reg + POS_W'(1);
                skip_next    = skip_upd;
                packets_next = packets_upd;
                closed_next  = closed_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            skip_reg    <= '0;
            packets_reg <= '0;
            closed_reg  <= 1'b0;
            ext_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            packets_reg <= packets_next;
            closed_reg  <= closed_next;
            ext_reg     <= ext_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Skipping always has bytes left to skip
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_reg != '0))
        else $error("skip phase with empty skip count");

    // Each byte adds at most one packet
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(packets_reg) <= 32'(pos_reg))
        else $error("packet count exceeds bytes consumed");

    // Record state restarts after each summary
    a_record_restart: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid |=> (pos_reg == '0 && phase_reg == PH_HEADER && packets_reg == '0))
        else $error("record state not cleared after summary");

    // Extended count moves by at most one per cycle
    a_ext_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ext_reg == $past(ext_reg)) || (ext_reg == $past(ext_reg) + EXT_W'(1)))
        else $error("extended count jumped");
`endif

endmodule

[design/profiling_record_header_parser_core.sv]
// Profiling record header parser: takes one record byte per transaction, records
// are RECORD_BYTES (64) bytes long, and after the last byte of each record one
// summary transaction gives status, packet count, end flag and the running
// extended-header total. Bytes are taken at one per cycle while the input is not
// stalled. Each byte goes through an input register, and the header walker works
// on it from there. The walker's record state and, on a record's last byte, the
// output register update at the same edge. The output register lets the next
// record stream in while a summary waits. The input stalls only when a record's
// last byte reaches the walker while the previous summary is still untaken.
module profiling_record_header_parser_core (
    input  logic          clk,
    input  logic          rst_n,
    prhp_byte_if.sink     record,
    prhp_result_if.source result
);
    import prhp_pkg::*;

    byte_item_t item;
    summary_t   summary;
    logic       take;
    logic       sum_valid;
    logic       out_free;
    logic       out_valid_reg;
    logic       out_valid_next;
    summary_t   out_data_reg;

    prhp_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .record (record),
        .take   (take),
        .item   (item)
    );

    prhp_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .out_free  (out_free),
        .take      (take),
        .sum_valid (sum_valid),
        .summary   (summary)
    );

    // Output register
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (sum_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid)
        begin
            out_data_reg <= summary;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_data_reg.status;
    assign result.packet_count   = out_data_reg.packet_count;
    assign result.end_seen       = out_data_reg.end_seen;
    assign result.extended_total = out_data_reg.extended_total;

`ifndef NO_ASSERTIONS
    // A new summary never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(sum_valid && out_valid_reg && !result.ready))
        else $error("summary overwrote pending result");

    // A summary is loaded exactly when the walker produced one
    a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid |=> out_valid_reg)
        else $error("summary not registered");

    // Status and end flag never both set
    a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.status && out_data_reg.end_seen))
        else $error("error status with end flag");
`endif

endmodule
